// ----- sv/brb_pkg.sv -----
// Package for the byte ring buffer: field widths, defaults, opcode and
// sequencer state types.
// No dependencies.
package brb_pkg;

  localparam int unsigned CFG_W       = 10;    // capacity register
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 7;     // length and done count
  localparam int unsigned OP_W        = 3;
  localparam int unsigned LEVEL_W     = 10;    // used and free fields
  localparam int unsigned MAX_BURST   = 64;
  localparam int unsigned RING_SLOTS_DEF = 1024;
  localparam int unsigned CAP_RESET   = 1023;

  localparam int unsigned S_TDATA_W = 16;      // data_in, length, padding
  localparam int unsigned S_TUSER_W = OP_W;
  localparam int unsigned M_TDATA_W = 40;      // data_out, done, used, free
  localparam int unsigned M_TUSER_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_SKIP   = 3'd3,
    OP_STATUS = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } state_e;

endpackage

// ----- sv/brb_wrap_add.sv -----
// Shared ring position unit: adds a step to a position and wraps it at
// the slot count. Depends on brb_pkg.
module brb_wrap_add #(
  parameter int unsigned PTR_W = 10
) (
  input  logic [PTR_W-1:0]          base_i,
  input  logic [brb_pkg::LEN_W-1:0] step_i,
  input  logic [PTR_W:0]            slots_i,
  output logic [PTR_W-1:0]          pos_o
);

  localparam int unsigned SUM_W =
    ((PTR_W > brb_pkg::LEN_W) ? PTR_W : brb_pkg::LEN_W) + 1;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] slots_ext;
  logic [SUM_W-1:0] wrapped;

  // step never reaches the slot count, so one subtract is enough
  always_comb begin
    sum       = SUM_W'(base_i) + SUM_W'(step_i);
    slots_ext = SUM_W'(slots_i);
    wrapped   = (sum >= slots_ext) ? (sum - slots_ext) : sum;
    pos_o     = PTR_W'(wrapped);
  end

endmodule

// ----- sv/brb_mem.sv -----
// Byte store of the ring: one write port, one read port with registered
// read data. Depends on brb_pkg.
module brb_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [brb_pkg::BYTE_W-1:0] wr_data_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [brb_pkg::BYTE_W-1:0] rd_data_o
);

  logic [brb_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [brb_pkg::BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/byte_ring_buffer.sv -----
// Top level of the byte ring buffer: request sequencer, positions, fill
// count and output register. Depends on brb_pkg, brb_wrap_add, brb_mem.
//
//   channel   dir  tdata                         tuser        tlast
//   s_axis    in   data_in, length               opcode       -
//   m_axis    out  data_out, done, used, free    data_valid   is_last
//   cfg       in   capacity (cfg_we_i strobe)    -            -
//
// Enqueue, skip, status and empty reads: accept, execute, load, then the
// word waits in the output register until taken. Dequeue and peek:
// execute, then for each byte a memory read, a load and a send, one after
// the other because of the single memory read port and the shared
// position adder. Reset empties the ring at once; no clearing pass.
// A stalled output holds the sequencer; no new request is taken meanwhile.
module byte_ring_buffer #(
  parameter int unsigned RING_SLOTS = brb_pkg::RING_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brb_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] data_in, [14:8] length, [15] zero
  input  logic [brb_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [2:0] opcode
  input  logic [brb_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] data_out, [14:8] done_count, [24:15] used_bytes,
  // [34:25] free_bytes, [39:35] zero
  output logic [brb_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] data_valid
  output logic [brb_pkg::M_TUSER_W-1:0] m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int unsigned PTR_W   = $clog2(RING_SLOTS);
  localparam int unsigned CAP_MAX = RING_SLOTS - 1;
  localparam int unsigned CAP_RST =
    (brb_pkg::CAP_RESET > CAP_MAX) ? CAP_MAX : brb_pkg::CAP_RESET;
  localparam int unsigned LW = brb_pkg::LEN_W;
  localparam int unsigned BW = brb_pkg::BYTE_W;

  brb_pkg::state_e state_q, state_d;

  logic [PTR_W-1:0] cap_q;
  logic [PTR_W-1:0] rp_q, rp_d;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [PTR_W-1:0] used_q, used_d;
  logic [PTR_W-1:0] pos_q, pos_d;
  logic [LW-1:0]    cnt_q, cnt_d;
  logic [LW-1:0]    done_q, done_d;
  logic             is_byte_q, is_byte_d;

  brb_pkg::op_e     op_q;
  logic [BW-1:0]    din_q;
  logic [LW-1:0]    len_q;

  logic             out_valid_q, out_valid_d;
  logic [BW-1:0]    out_data_q, out_data_d;
  logic             out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic [LW-1:0]    out_done_q, out_done_d;
  logic [PTR_W-1:0] out_used_q, out_used_d;
  logic [PTR_W-1:0] out_free_q, out_free_d;

  logic [PTR_W-1:0] cap_wr;
  logic [PTR_W:0]   slots;
  logic [LW-1:0]    len_in;
  logic [LW-1:0]    burst;
  logic [PTR_W-1:0] au_base;
  logic [LW-1:0]    au_step;
  logic [PTR_W-1:0] au_pos;
  logic             mem_we;
  logic [BW-1:0]    rd_data;
  logic             in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign slots  = {1'b0, cap_q} + (PTR_W + 1)'(1);

  // clamp the capacity write to 1 .. RING_SLOTS-1
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_wr = PTR_W'(1);
    end else if (32'(cfg_wdata_i) > 32'(CAP_MAX)) begin
      cap_wr = PTR_W'(CAP_MAX);
    end else begin
      cap_wr = PTR_W'(cfg_wdata_i);
    end
  end

  assign len_in = (32'(s_axis_tdata[14:8]) > 32'(brb_pkg::MAX_BURST)) ?
                  LW'(brb_pkg::MAX_BURST) : s_axis_tdata[14:8];

  // bytes this request can move: min(length, used)
  assign burst = (32'(used_q) < 32'(len_q)) ? LW'(used_q) : len_q;

  brb_wrap_add #(
    .PTR_W (PTR_W)
  ) u_wrap (
    .base_i  (au_base),
    .step_i  (au_step),
    .slots_i (slots),
    .pos_o   (au_pos)
  );

  brb_mem #(
    .DEPTH (RING_SLOTS),
    .AW    (PTR_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (wp_q),
    .wr_data_i (din_q),
    .rd_addr_i (pos_q),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    used_d      = used_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    done_d      = done_q;
    is_byte_d   = is_byte_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    out_used_d  = out_used_q;
    out_free_d  = out_free_q;
    au_base     = pos_q;
    au_step     = LW'(1);
    mem_we      = 1'b0;
    s_axis_tready = 1'b0;

    case (state_q)
      brb_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          state_d = brb_pkg::ST_EXEC;
        end
      end
      brb_pkg::ST_EXEC: begin
        is_byte_d = 1'b0;
        done_d    = '0;
        state_d   = brb_pkg::ST_LOAD;
        case (op_q)
          brb_pkg::OP_ENQ: begin
            au_base = wp_q;
            au_step = LW'(1);
            if (used_q < cap_q) begin
              mem_we = 1'b1;
              wp_d   = au_pos;
              used_d = used_q + PTR_W'(1);
              done_d = LW'(1);
            end
          end
          brb_pkg::OP_DEQ, brb_pkg::OP_PEEK: begin
            done_d = burst;
            if (burst != '0) begin
              is_byte_d = 1'b1;
              pos_d     = rp_q;
              cnt_d     = '0;
              state_d   = brb_pkg::ST_READ;
              // levels in every word show the state after the dequeue
              if (op_q == brb_pkg::OP_DEQ) begin
                used_d = used_q - PTR_W'(burst);
              end
            end
          end
          brb_pkg::OP_SKIP: begin
            au_base = rp_q;
            au_step = burst;
            done_d  = burst;
            rp_d    = au_pos;
            used_d  = used_q - PTR_W'(burst);
          end
          default: begin
            // status and unused codes
          end
        endcase
      end
      brb_pkg::ST_READ: begin
        // memory reads pos_q this cycle; advance to the next slot
        au_base = pos_q;
        au_step = LW'(1);
        pos_d   = au_pos;
        state_d = brb_pkg::ST_LOAD;
      end
      brb_pkg::ST_LOAD: begin
        out_valid_d = 1'b1;
        out_byte_d  = is_byte_q;
        out_data_d  = is_byte_q ? rd_data : '0;
        out_last_d  = !is_byte_q || ((cnt_q + LW'(1)) == done_q);
        out_done_d  = done_q;
        out_used_d  = used_q;
        out_free_d  = cap_q - used_q;
        cnt_d       = cnt_q + LW'(1);
        state_d     = brb_pkg::ST_SEND;
      end
      brb_pkg::ST_SEND: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            if (is_byte_q && op_q == brb_pkg::OP_DEQ) begin
              rp_d = pos_q;
            end
            state_d = brb_pkg::ST_IDLE;
          end else begin
            state_d = brb_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_d = brb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brb_pkg::ST_IDLE;
      cap_q       <= PTR_W'(CAP_RST);
      rp_q        <= '0;
      wp_q        <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        // a capacity write empties the ring
        cap_q  <= cap_wr;
        rp_q   <= '0;
        wp_q   <= '0;
        used_q <= '0;
      end else begin
        rp_q   <= rp_d;
        wp_q   <= wp_d;
        used_q <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    cnt_q      <= cnt_d;
    done_q     <= done_d;
    is_byte_q  <= is_byte_d;
    out_data_q <= out_data_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
    out_used_q <= out_used_d;
    out_free_q <= out_free_d;
    if (in_acc) begin
      op_q  <= brb_pkg::op_e'(s_axis_tuser[brb_pkg::OP_W-1:0]);
      din_q <= s_axis_tdata[7:0];
      len_q <= len_in;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_byte_q;
  assign m_axis_tdata  = {5'd0,
                          brb_pkg::LEVEL_W'(out_free_q),
                          brb_pkg::LEVEL_W'(out_used_q),
                          out_done_q,
                          out_data_q};

endmodule

// ----- sv/brb_checker.sv -----
// Port checker for the byte ring buffer, bound to the top level.
// Depends on brb_pkg and byte_ring_buffer.
module brb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [brb_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [brb_pkg::M_TUSER_W-1:0] m_axis_tuser,
  input logic                          m_axis_tlast
);

  // one request at a time: never ready while a word waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while an output word is pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // a word without a byte ends its request and carries a zero byte
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
    else $error("word without data is not a final zero word");

  // byte words carry a nonzero count, and only byte words are not last
  a_byte_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] || !m_axis_tlast) |->
      m_axis_tuser[0] && m_axis_tdata[14:8] != 7'd0)
    else $error("byte word with zero count or non-final empty word");

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking bench for byte_ring_buffer: drives requests on s_axis, mirrors
// the ring in a behavioural model and checks every m_axis word against it.
// Depends on brb_pkg and byte_ring_buffer.
module tb_top;

  localparam int unsigned BYTE_W         = brb_pkg::BYTE_W;
  localparam int unsigned LEN_W          = brb_pkg::LEN_W;
  localparam int unsigned LEVEL_W        = brb_pkg::LEVEL_W;
  localparam int unsigned OP_W           = brb_pkg::OP_W;
  localparam int unsigned CFG_W          = brb_pkg::CFG_W;
  localparam int unsigned S_TDATA_W      = brb_pkg::S_TDATA_W;
  localparam int unsigned S_TUSER_W      = brb_pkg::S_TUSER_W;
  localparam int unsigned M_TDATA_W      = brb_pkg::M_TDATA_W;
  localparam int unsigned M_TUSER_W      = brb_pkg::M_TUSER_W;
  localparam int unsigned RING_SLOTS_DEF = brb_pkg::RING_SLOTS_DEF;
  localparam int unsigned MAX_BURST      = brb_pkg::MAX_BURST;
  localparam int unsigned CAP_RESET      = brb_pkg::CAP_RESET;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
  localparam int unsigned OP_CODE_MAX = (1 << OP_W) - 1;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned FULL_CAP = 48;
  localparam int unsigned RAND_ITEMS = 34;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_out;
    logic               data_valid;
    logic               is_last;
    logic [LEN_W-1:0]   done_count;
    logic [LEVEL_W-1:0] used_bytes;
    logic [LEVEL_W-1:0] free_bytes;
  } ring_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;

  // ring mirror
  logic [BYTE_W-1:0] ring_mem [RING_SLOTS_DEF];
  int unsigned       rd_pos;
  int unsigned       wr_pos;
  int unsigned       cap_reg;
  ring_word_t        response_q [$];

  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned words_checked;
  int unsigned cap_writes;
  int unsigned cycle_count;
  int unsigned hold_cycles;
  bit          gaps_on;

  byte_ring_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned ring_slots();
    int unsigned c;
    c = cap_reg;
    if (c < 1) c = 1;
    if (c > RING_SLOTS_DEF - 1) c = RING_SLOTS_DEF - 1;
    return c + 1;
  endfunction

  function automatic int unsigned fill_level();
    int unsigned s;
    s = ring_slots();
    return (wr_pos + s - rd_pos) % s;
  endfunction

  // Levels are taken after the request has moved the positions.
  function automatic void push_word(input int unsigned data, input bit valid,
                                    input bit last, input int unsigned done);
    ring_word_t w;
    int unsigned held;
    held         = fill_level();
    w.data_out   = BYTE_W'(data);
    w.data_valid = valid;
    w.is_last    = last;
    w.done_count = LEN_W'(done);
    w.used_bytes = LEVEL_W'(held);
    w.free_bytes = LEVEL_W'(ring_slots() - 1 - held);
    response_q.push_back(w);
  endfunction

  function automatic void predict_request(input logic [OP_W-1:0] op,
                                          input logic [BYTE_W-1:0] din,
                                          input logic [LEN_W-1:0] len);
    int unsigned slots, held, want, n, pos, i;
    slots = ring_slots();
    held  = fill_level();
    want  = (32'(len) > MAX_BURST) ? MAX_BURST : 32'(len);
    n     = (want < held) ? want : held;
    case (op)
      brb_pkg::OP_ENQ: begin
        if (held < slots - 1) begin
          ring_mem[wr_pos] = din;
          wr_pos = (wr_pos + 1) % slots;
          push_word(0, 1'b0, 1'b1, 1);
        end else begin
          push_word(0, 1'b0, 1'b1, 0);
        end
      end
      brb_pkg::OP_DEQ, brb_pkg::OP_PEEK: begin
        if (n == 0) begin
          push_word(0, 1'b0, 1'b1, 0);
        end else begin
          pos = rd_pos;
          if (op == brb_pkg::OP_DEQ) rd_pos = (rd_pos + n) % slots;
          for (i = 0; i < n; i++) begin
            push_word(32'(ring_mem[pos]), 1'b1, i + 1 == n, n);
            pos = (pos + 1) % slots;
          end
        end
      end
      brb_pkg::OP_SKIP: begin
        rd_pos = (rd_pos + n) % slots;
        push_word(0, 1'b0, 1'b1, n);
      end
      default: begin
        push_word(0, 1'b0, 1'b1, 0);
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_word();
    ring_word_t exp_word;
    if (response_q.size() == 0) begin
      $error("word with none expected: tdata %h", m_axis_tdata);
      fail_count++;
    end else begin
      exp_word = response_q.pop_front();
      compare_field("data_out", 32'(exp_word.data_out), 32'(m_axis_tdata[7:0]));
      compare_field("data_valid", 32'(exp_word.data_valid), 32'(m_axis_tuser[0]));
      compare_field("is_last", 32'(exp_word.is_last), 32'(m_axis_tlast));
      compare_field("done_count", 32'(exp_word.done_count), 32'(m_axis_tdata[14:8]));
      compare_field("used_bytes", 32'(exp_word.used_bytes), 32'(m_axis_tdata[24:15]));
      compare_field("free_bytes", 32'(exp_word.free_bytes), 32'(m_axis_tdata[34:25]));
      words_checked++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_word();
  end

  // Output side: random stall before each word, plus a long hold on request.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_cycles != 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (hold_cycles - 1) @(negedge clk_i);
        hold_cycles = 0;
      end
      stall = gaps_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
             response_q.size());
    $display("byte_ring_buffer regression: fail");
    $finish;
  end

  // Leave tvalid high after acceptance; the next call either replaces the
  // word or drops tvalid for the gap.
  task automatic send_request(input int unsigned op, input int unsigned din,
                              input int unsigned len);
    int unsigned       gap;
    logic [OP_W-1:0]   op_v;
    logic [BYTE_W-1:0] din_v;
    logic [LEN_W-1:0]  len_v;
    op_v  = OP_W'(op);
    din_v = BYTE_W'(din);
    len_v = LEN_W'(len);
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, len_v, din_v};
    s_axis_tuser  <= op_v;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(op_v, din_v, len_v);
    items_sent++;
  endtask

  task automatic drain_responses();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (response_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input int unsigned value);
    drain_responses();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(value);
    @(negedge clk_i) cfg_we_i <= 1'b0;
    cap_reg = value;
    rd_pos  = 0;
    wr_pos  = 0;
    cap_writes++;
  endtask

  // Mostly short requests, a few saturating ones.
  function automatic int unsigned rand_length();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(0, 16);
    if (pick < 9) return $urandom_range(17, MAX_BURST);
    return $urandom_range(MAX_BURST + 1, LEN_MAX);
  endfunction

  task automatic test_basic_ops();
    gaps_on = 1'b1;
    send_request(brb_pkg::OP_STATUS, 8'h00, 0);
    send_request(brb_pkg::OP_DEQ, 8'h00, 5);
    send_request(brb_pkg::OP_PEEK, 8'h00, 0);
    send_request(brb_pkg::OP_SKIP, 8'h00, 3);
    send_request(brb_pkg::OP_ENQ, 8'h00, 0);
    send_request(brb_pkg::OP_ENQ, 8'hFF, LEN_MAX);
    send_request(brb_pkg::OP_ENQ, 8'hA5, 0);
    send_request(brb_pkg::OP_ENQ, 8'h5A, 0);
    send_request(brb_pkg::OP_PEEK, 8'hFF, 0);
    send_request(brb_pkg::OP_PEEK, 8'h00, LEN_MAX);
    send_request(brb_pkg::OP_DEQ, 8'h00, 1);
    send_request(brb_pkg::OP_SKIP, 8'h00, 1);
    send_request(brb_pkg::OP_STATUS + 1, 8'h00, 0);
    send_request(brb_pkg::OP_STATUS + 2, 8'h00, 0);
    send_request(OP_CODE_MAX, 8'hFF, LEN_MAX);
    send_request(brb_pkg::OP_DEQ, 8'h00, MAX_BURST);
    send_request(brb_pkg::OP_ENQ, 8'h3C, 0);
    send_request(brb_pkg::OP_SKIP, 8'h00, LEN_MAX);
    send_request(brb_pkg::OP_DEQ, 8'h00, 1);
    // zero capacity clamps to a single byte
    write_capacity(0);
    send_request(brb_pkg::OP_ENQ, 8'h11, 0);
    send_request(brb_pkg::OP_ENQ, 8'h22, 0);
    send_request(brb_pkg::OP_STATUS, 8'h00, 0);
    send_request(brb_pkg::OP_DEQ, 8'h00, MAX_BURST);
    send_request(brb_pkg::OP_PEEK, 8'h00, MAX_BURST);
  endtask

  // Fill a ring, overflow it, then wrap and empty it.
  task automatic test_full_ring();
    int unsigned i;
    write_capacity(FULL_CAP);
    gaps_on = 1'b0;
    for (i = 0; i < FULL_CAP + 2; i++) begin
      send_request(brb_pkg::OP_ENQ, $urandom_range(0, 255), 0);
    end
    send_request(brb_pkg::OP_STATUS, 8'h00, 0);
    send_request(brb_pkg::OP_DEQ, 8'h00, MAX_BURST);
    for (i = 0; i < 10; i++) send_request(brb_pkg::OP_ENQ, $urandom_range(0, 255), 0);
    send_request(brb_pkg::OP_PEEK, 8'h00, LEN_MAX);
    send_request(brb_pkg::OP_SKIP, 8'h00, 3);
    while (fill_level() != 0) send_request(brb_pkg::OP_DEQ, 8'h00, 4);
    send_request(brb_pkg::OP_STATUS, 8'h00, 0);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned caps [7] = '{1, 2, 0, 17, 200, 3, CAP_RESET};
    int unsigned enq_pct [7] = '{50, 50, 50, 55, 70, 50, 70};
    int unsigned ph, i, pick;
    int unsigned op;
    caps[5] = $urandom_range(3, CAP_RESET - 1);
    for (ph = 0; ph < 7; ph++) begin
      write_capacity(caps[ph]);
      // one phase runs flat out on both sides
      gaps_on = (ph != 3);
      for (i = 0; i < RAND_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < enq_pct[ph])                  op = brb_pkg::OP_ENQ;
        else if (pick < enq_pct[ph] + 15)        op = brb_pkg::OP_DEQ;
        else if (pick < enq_pct[ph] + 24)        op = brb_pkg::OP_PEEK;
        else if (pick < enq_pct[ph] + 32)        op = brb_pkg::OP_SKIP;
        else if (pick < 97)                      op = brb_pkg::OP_STATUS;
        else op = $urandom_range(brb_pkg::OP_STATUS + 1, OP_CODE_MAX);
        send_request(op, $urandom_range(0, 255), rand_length());
      end
    end
    gaps_on = 1'b1;
  endtask

  // Hold the output long enough that the block stops taking requests.
  task automatic test_backpressure();
    int unsigned i;
    write_capacity(8);
    gaps_on = 1'b0;
    hold_cycles = HOLD_CYCLES;
    for (i = 0; i < 40; i++) begin
      if (i % 5 == 4) send_request(brb_pkg::OP_PEEK, 8'h00, LEN_MAX);
      else            send_request(brb_pkg::OP_ENQ, $urandom_range(0, 255), 0);
    end
    drain_responses();
    for (i = 0; i < 12; i++) send_request(brb_pkg::OP_DEQ, 8'h00, 2);
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    fail_count    = 0;
    items_sent    = 0;
    words_checked = 0;
    cap_writes    = 0;
    hold_cycles   = 0;
    gaps_on       = 1'b1;
    cap_reg       = CAP_RESET;
    rd_pos        = 0;
    wr_pos        = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_full_ring();
    test_random_traffic();
    test_backpressure();

    drain_responses();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (response_q.size() != 0) begin
      $error("%0d expected words never arrived", response_q.size());
      fail_count++;
    end
    $display("covered: %0d requests (all opcodes, overflow, saturation, wrap), %0d words",
             items_sent, words_checked);
    $display("covered: %0d capacity writes from zero to full size, %0d mismatches",
             cap_writes, fail_count);
    if (fail_count == 0) begin
      $display("byte_ring_buffer regression: pass");
    end else begin
      $display("byte_ring_buffer regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/brb_pkg.sv
sv/brb_wrap_add.sv
sv/brb_mem.sv
sv/byte_ring_buffer.sv
sv/brb_checker.sv
tb/tb_top.sv
